// ===== hdl/ssts_pkg.sv =====
package ssts_pkg;

	// default geometry of the table
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int SIZE_WIDTH_DEF  = 31;

	// fixed field widths
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int COUNT_OUT_W = 7;
	localparam int CFG_W       = 2;
	localparam int CFG_IDX_W   = 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_MAP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_SNAPPED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PASS     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CLAMPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

	// rounding modes
	localparam logic [1:0] RND_UP      = 2'd0;
	localparam logic [1:0] RND_NEAREST = 2'd1;
	localparam logic [1:0] RND_DOWN    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLE = 1'b1;

endpackage

// ===== hdl/sorted_size_table_snap.sv =====
// Sorted size table with snapping of requested sizes.
// Input: pulse start with cmd and size_value while busy is low; the beat is taken
// at that edge. cmd selects map, insert or clear. Output: done is high for exactly
// one cycle with mapped_size, status and entry_count; the receiver cannot stall, so
// every result must be taken in that cycle. Configuration: cfg_wr_en with cfg_index
// and cfg_wdata writes round_mode (index 0) or map_enable (index 1), taken at once.
// Clear, passthrough and a full-table insert give done in the cycle after the
// accepting edge. A map reads the smallest entry (snap if at or below it), then the
// largest (clamp if above), then runs a binary search with one table read per probe
// through the single read port, and rounds. An insert moves each entry at or above
// the size up one place, one memory read and write each, then writes the size. busy
// stays high until the result is issued; the next item may start in the done cycle.
// Reset clears the entry count and the configuration (round up, mapping on); table
// contents are left as they are and only entries below the count are ever read.
module sorted_size_table_snap #(
	parameter int TABLE_DEPTH = ssts_pkg::TABLE_DEPTH_DEF,
	parameter int SIZE_WIDTH  = ssts_pkg::SIZE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ssts_pkg::CMD_W-1:0]        cmd,
	input  logic [SIZE_WIDTH-1:0]             size_value,
	output logic                              done,
	output logic [SIZE_WIDTH-1:0]             mapped_size,
	output logic [ssts_pkg::STATUS_W-1:0]     status,
	output logic [ssts_pkg::COUNT_OUT_W-1:0]  entry_count,
	input  logic                              cfg_wr_en,
	input  logic [ssts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssts_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int IW = $clog2(TABLE_DEPTH);

	logic [1:0]            round_mode_q;
	logic                  map_enable_q;
	logic                  rd_en, wr_en;
	logic [IW-1:0]         rd_addr, wr_addr;
	logic [SIZE_WIDTH-1:0] rd_data, wr_data;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= ssts_pkg::RND_UP;
			map_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ssts_pkg::REG_ROUND_MODE: round_mode_q <= cfg_wdata;
				ssts_pkg::REG_MAP_ENABLE: map_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	ssts_seq #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.size_value (size_value),
		.round_mode (round_mode_q),
		.map_enable (map_enable_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.done       (done),
		.mapped_size(mapped_size),
		.status     (status),
		.entry_count(entry_count)
	);

	ssts_mem #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

// ===== hdl/ssts_mem.sv =====
module ssts_mem #(
	parameter int TABLE_DEPTH = ssts_pkg::TABLE_DEPTH_DEF,
	parameter int SIZE_WIDTH  = ssts_pkg::SIZE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [SIZE_WIDTH-1:0]          rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [SIZE_WIDTH-1:0]          wr_data
);

	logic [SIZE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [SIZE_WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/ssts_seq.sv =====
module ssts_seq #(
	parameter int TABLE_DEPTH = ssts_pkg::TABLE_DEPTH_DEF,
	parameter int SIZE_WIDTH  = ssts_pkg::SIZE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ssts_pkg::CMD_W-1:0]        cmd,
	input  logic [SIZE_WIDTH-1:0]             size_value,
	input  logic [1:0]                        round_mode,
	input  logic                              map_enable,
	output logic                              rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
	input  logic [SIZE_WIDTH-1:0]             rd_data,
	output logic                              wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
	output logic [SIZE_WIDTH-1:0]             wr_data,
	output logic                              done,
	output logic [SIZE_WIDTH-1:0]             mapped_size,
	output logic [ssts_pkg::STATUS_W-1:0]     status,
	output logic [ssts_pkg::COUNT_OUT_W-1:0]  entry_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FIRST  = 7'b0000010,
		S_LAST   = 7'b0000100,
		S_SEARCH = 7'b0001000,
		S_ROUND  = 7'b0010000,
		S_CHK    = 7'b0100000,
		S_PUT    = 7'b1000000
	} state_t;

	state_t                         state_q, state_d;
	logic [SIZE_WIDTH-1:0]          v_q, v_d;
	logic [CW-1:0]                  count_q, count_d;
	logic [IW-1:0]                  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
	logic [SIZE_WIDTH-1:0]          below_q, below_d, above_q, above_d;
	logic                           done_q, done_d;
	logic [SIZE_WIDTH-1:0]          mapped_q, mapped_d;
	logic [ssts_pkg::STATUS_W-1:0]  status_q, status_d;

	logic                  v_gt_rd;
	logic [IW-1:0]         step_lo, step_hi, step_mid, last_idx;
	logic                  step_open;
	logic [SIZE_WIDTH-1:0] dist_lo, dist_hi, rounded;

	// compare against the beat just read, narrow the search window
	assign v_gt_rd   = v_q > rd_data;
	assign last_idx  = IW'(count_q - CW'(1));
	assign step_lo   = (state_q == S_LAST) ? '0 : (v_gt_rd ? mid_q : lo_q);
	assign step_hi   = (state_q == S_LAST) ? last_idx : (v_gt_rd ? hi_q : mid_q);
	assign step_mid  = IW'(({1'b0, step_lo} + {1'b0, step_hi}) >> 1);
	assign step_open = (step_hi - step_lo) > IW'(1);

	// pick between the two neighbours; a tie goes down
	assign dist_lo = v_q - below_q;
	assign dist_hi = above_q - v_q;
	always_comb begin
		case (round_mode)
			ssts_pkg::RND_UP:      rounded = above_q;
			ssts_pkg::RND_NEAREST: rounded = (dist_lo > dist_hi) ? above_q : below_q;
			ssts_pkg::RND_DOWN:    rounded = (v_q == above_q) ? above_q : below_q;
			default:               rounded = above_q;
		endcase
	end

	// sequencer: memory requests and next state
	always_comb begin
		state_d  = state_q;
		v_d      = v_q;
		count_d  = count_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		j_d      = j_q;
		below_d  = below_q;
		above_d  = above_q;
		done_d   = 1'b0;
		mapped_d = mapped_q;
		status_d = status_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = j_q;
		wr_data  = v_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					v_d      = size_value;
					mapped_d = size_value;
					case (cmd)
						ssts_pkg::CMD_MAP: begin
							if (count_q == '0 || !map_enable) begin
								done_d   = 1'b1;
								status_d = ssts_pkg::ST_PASS;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = S_FIRST;
							end
						end
						ssts_pkg::CMD_INSERT: begin
							if (count_q == CW'(TABLE_DEPTH)) begin
								done_d   = 1'b1;
								status_d = ssts_pkg::ST_FULL;
							end else if (count_q == '0) begin
								j_d     = '0;
								state_d = S_PUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = last_idx;
								j_d     = IW'(count_q);
								state_d = S_CHK;
							end
						end
						ssts_pkg::CMD_CLEAR: begin
							count_d  = '0;
							done_d   = 1'b1;
							status_d = ssts_pkg::ST_CLEARED;
						end
						default: begin
							done_d   = 1'b1;
							status_d = ssts_pkg::ST_PASS;
						end
					endcase
				end
			end
			S_FIRST: begin
				if (!v_gt_rd) begin
					done_d   = 1'b1;
					mapped_d = rd_data;
					status_d = ssts_pkg::ST_SNAPPED;
					state_d  = S_IDLE;
				end else begin
					below_d = rd_data;
					rd_en   = 1'b1;
					rd_addr = last_idx;
					state_d = S_LAST;
				end
			end
			S_LAST, S_SEARCH: begin
				if (state_q == S_LAST && v_gt_rd) begin
					done_d   = 1'b1;
					mapped_d = rd_data;
					status_d = ssts_pkg::ST_CLAMPED;
					state_d  = S_IDLE;
				end else begin
					if (state_q == S_LAST || !v_gt_rd) begin
						above_d = rd_data;
					end else begin
						below_d = rd_data;
					end
					lo_d = step_lo;
					hi_d = step_hi;
					if (step_open) begin
						mid_d   = step_mid;
						rd_en   = 1'b1;
						rd_addr = step_mid;
						state_d = S_SEARCH;
					end else begin
						state_d = S_ROUND;
					end
				end
			end
			S_ROUND: begin
				done_d   = 1'b1;
				mapped_d = rounded;
				status_d = ssts_pkg::ST_SNAPPED;
				state_d  = S_IDLE;
			end
			S_CHK: begin
				wr_en = 1'b1;
				if (rd_data >= v_q) begin
					// move an entry not below the new size up one place and read the next one down, if any
					wr_data = rd_data;
					j_d     = j_q - IW'(1);
					if (j_q == IW'(1)) begin
						state_d = S_PUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = j_q - IW'(2);
					end
				end else begin
					count_d  = count_q + CW'(1);
					done_d   = 1'b1;
					status_d = ssts_pkg::ST_INSERTED;
					state_d  = S_IDLE;
				end
			end
			S_PUT: begin
				wr_en    = 1'b1;
				count_d  = count_q + CW'(1);
				done_d   = 1'b1;
				status_d = ssts_pkg::ST_INSERTED;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		v_q      <= v_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		j_q      <= j_d;
		below_q  <= below_d;
		above_q  <= above_d;
		mapped_q <= mapped_d;
		status_q <= status_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign mapped_size = mapped_q;
	assign status      = status_q;
	assign entry_count = ssts_pkg::COUNT_OUT_W'(count_q);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result beat while sequencer busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CHK || state_q == S_PUT))
		else $error("table write outside insertion");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (lo_q < mid_q && mid_q < hi_q))
		else $error("search probe outside window");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ssts_pkg::ST_INSERTED) |-> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table by one");

endmodule
